// ----- rtl/mbt_pkg.sv -----
`timescale 1ns / 1ps
package mbt_pkg;

  localparam int MAXN    = 16;
  localparam int SLOTS   = MAXN + 1;
  localparam int W_DEPTH = 3 * SLOTS * MAXN;
  localparam int W_AW    = 10;
  localparam int N_DEPTH = 64;
  localparam int N_AW    = 6;

  localparam logic signed [15:0] ONE_FX = 16'sd4096;

  // item operation codes
  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_INPUT  = 2'd1;
  localparam logic [1:0] OP_TARGET = 2'd2;

  // result kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_LAYERS = 3'd0;
  localparam logic [2:0] CFG_SIZE0  = 3'd1;
  localparam logic [2:0] CFG_SIZE1  = 3'd2;
  localparam logic [2:0] CFG_SIZE2  = 3'd3;
  localparam logic [2:0] CFG_SIZE3  = 3'd4;
  localparam logic [2:0] CFG_RATE   = 3'd5;

  typedef struct packed {
    logic [2:0]  layer_count;
    logic [4:0]  size0;
    logic [4:0]  size1;
    logic [4:0]  size2;
    logic [4:0]  size3;
    logic [15:0] rate;
  } cfg_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_WR_W,
    DP_WR_IN,
    DP_WR_TGT,
    DP_RD,
    DP_ACC_CLR,
    DP_ACC,
    DP_RND,
    DP_ERR,
    DP_DER,
    DP_GRAD,
    DP_GLATCH,
    DP_PRND,
    DP_WUPD,
    DP_TANH_A,
    DP_TANH_B,
    DP_OUT_LD,
    DP_DONE_LD
  } dp_op_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_NW,
    MS_WG,
    MS_YY,
    MS_ED,
    MS_NG,
    MS_LP
  } mul_sel_t;

  typedef struct packed {
    dp_op_t             op;
    mul_sel_t           mul;
    logic [W_AW-1:0]    w_addr;
    logic [6:0]         n_addr;
    logic [5:0]         g_addr;
    logic [3:0]         t_idx;
    logic signed [15:0] data;
    logic [3:0]         out_idx;
    logic               out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  // tanh(k/4) in Q.12
  function automatic logic [12:0] tanh_lut(input logic [5:0] k);
    logic [12:0] v;
    case (k)
      6'd0:  v = 13'd0;
      6'd1:  v = 13'd1003;
      6'd2:  v = 13'd1893;
      6'd3:  v = 13'd2602;
      6'd4:  v = 13'd3119;
      6'd5:  v = 13'd3475;
      6'd6:  v = 13'd3707;
      6'd7:  v = 13'd3856;
      6'd8:  v = 13'd3949;
      6'd9:  v = 13'd4006;
      6'd10: v = 13'd4041;
      6'd11: v = 13'd4062;
      6'd12: v = 13'd4076;
      6'd13: v = 13'd4084;
      6'd14: v = 13'd4089;
      6'd15: v = 13'd4091;
      6'd16: v = 13'd4093;
      6'd17: v = 13'd4094;
      6'd18: v = 13'd4095;
      6'd19: v = 13'd4095;
      default: v = 13'd4096;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/mbt_in_if.sv -----
`timescale 1ns / 1ps
interface mbt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [1:0]         source_layer;
  logic [4:0]         source_index;
  logic [3:0]         dest_index;
  logic signed [15:0] value;
  logic               last;

  modport source (output valid, operation, source_layer, source_index, dest_index, value,
                  last, input ready);
  modport sink (input valid, operation, source_layer, source_index, dest_index, value,
                last, output ready);
endinterface

// ----- rtl/mbt_out_if.sv -----
`timescale 1ns / 1ps
interface mbt_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [3:0]         output_index;
  logic signed [15:0] output_value;
  logic               last_result;

  modport source (output valid, result_kind, output_index, output_value, last_result,
                  input ready);
  modport sink (input valid, result_kind, output_index, output_value, last_result,
                output ready);
endinterface

// ----- rtl/mbt_cfg_if.sv -----
`timescale 1ns / 1ps
interface mbt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mlp_backprop_trainer_unit.sv -----
`timescale 1ns / 1ps
// Trainable multilayer perceptron, Q3.12 values, tanh activation.
// in_if carries items: weight writes, input elements and target elements.
// An input element with last set runs a forward pass; the output layer
// values then leave on out_if, one item per neuron, last_result on the final.
// A target element with last set runs backpropagation and the weight update,
// then sends one done item. cfg_if writes the registers and is always ready;
// it is only to be written while the block is idle, which the block does not enforce.
// Weight writes and non-last elements leave the block idle and ready for more.
// Forward pass: each neuron reads, multiplies and accumulates every source and
// then the bias through the single multiplier, then rounds and applies tanh.
// Training computes output and hidden gradients, then updates the weights.
// All of this work shares the one multiplier and the single weight memory port.
// Reset loads the register defaults, clears neuron outputs (bias slots read
// 1.0) and targets; weights and gradients hold nothing until written.
// A stalled receiver holds the result register; the block waits on it only
// when it has a new result to send.
module mlp_backprop_trainer_unit (
  input logic         clk,
  input logic         rst_n,
  mbt_in_if.sink      in_if,
  mbt_out_if.source   out_if,
  mbt_cfg_if.sink     cfg_if
);
  import mbt_pkg::*;

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layer_count <= 3'd3;
      cfg_r.size0 <= 5'd2;
      cfg_r.size1 <= 5'd4;
      cfg_r.size2 <= 5'd1;
      cfg_r.size3 <= 5'd1;
      cfg_r.rate <= 16'd9830;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_LAYERS: cfg_r.layer_count <= cfg_if.data[2:0];
        CFG_SIZE0:  cfg_r.size0 <= cfg_if.data[4:0];
        CFG_SIZE1:  cfg_r.size1 <= cfg_if.data[4:0];
        CFG_SIZE2:  cfg_r.size2 <= cfg_if.data[4:0];
        CFG_SIZE3:  cfg_r.size3 <= cfg_if.data[4:0];
        CFG_RATE:   cfg_r.rate <= cfg_if.data;
        default: ;
      endcase
    end
  end

  mbt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_operation    (in_if.operation),
    .in_source_layer (in_if.source_layer),
    .in_source_index (in_if.source_index),
    .in_dest_index   (in_if.dest_index),
    .in_value        (in_if.value),
    .in_last         (in_if.last),
    .sts             (sts),
    .cmd             (cmd)
  );

  mbt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rate      (cfg_r.rate),
    .out_ready (out_if.ready),
    .sts       (sts),
    .out_valid (out_if.valid),
    .out_kind  (out_if.result_kind),
    .out_idx   (out_if.output_index),
    .out_val   (out_if.output_value),
    .out_last  (out_if.last_result)
  );

endmodule

// ----- rtl/mbt_datapath.sv -----
`timescale 1ns / 1ps
module mbt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  mbt_pkg::dp_cmd_t   cmd,
  input  logic [15:0]        rate,
  input  logic               out_ready,
  output mbt_pkg::dp_sts_t   sts,
  output logic               out_valid,
  output logic               out_kind,
  output logic [3:0]         out_idx,
  output logic signed [15:0] out_val,
  output logic               out_last
);
  import mbt_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] x);
    logic signed [15:0] r;
    if (x > 40'sd32767) r = 16'sh7fff;
    else if (x < -40'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  // round to nearest at bit 12, ties up
  function automatic logic signed [39:0] rnd12(input logic signed [39:0] x);
    logic signed [39:0] t;
    t = x + 40'sd2048;
    return t >>> 12;
  endfunction

  logic signed [15:0] wmem [W_DEPTH];
  logic signed [15:0] nmem [N_DEPTH];
  logic signed [15:0] gmem [N_DEPTH];
  logic [N_DEPTH-1:0] nvalid_r;
  logic signed [15:0] tgt_r [MAXN];

  logic signed [15:0] w_q_r, n_q_r, g_q_r, t_q_r;
  logic               n_bias_r, n_vld_r;
  logic signed [33:0] prod_r;
  logic signed [39:0] acc_r;
  logic signed [15:0] e_r, d_r, p_r, g_hold_r;
  logic [12:0]        t0_r;
  logic [19:0]        tprod_r;
  logic               neg_r, big_r;

  logic               out_valid_r, out_kind_r, out_last_r;
  logic [3:0]         out_idx_r;
  logic signed [15:0] out_val_r;

  logic [N_AW-1:0]    n_idx;
  logic signed [15:0] nv;
  logic signed [16:0] ma, mb;
  logic signed [39:0] prod_x, delta;
  logic signed [15:0] w_upd, n_wdata, w_wdata, grad_val;
  logic               w_we, n_we;
  logic [16:0]        t_abs;
  logic [12:0]        t1, tdiff;
  logic [12:0]        t_mag;
  logic [19:0]        tround;

  assign n_idx = {cmd.n_addr[6:5], cmd.n_addr[3:0]};
  assign nv = n_bias_r ? ONE_FX : (n_vld_r ? n_q_r : 16'sd0);
  assign prod_x = 40'(prod_r);

  always_comb begin
    case (cmd.mul)
      MS_NW:   begin ma = 17'(nv);              mb = 17'(w_q_r); end
      MS_WG:   begin ma = 17'(w_q_r);           mb = 17'(g_q_r); end
      MS_YY:   begin ma = 17'(nv);              mb = 17'(nv); end
      MS_ED:   begin ma = 17'(e_r);             mb = 17'(d_r); end
      MS_NG:   begin ma = 17'(nv);              mb = 17'(g_hold_r); end
      MS_LP:   begin ma = $signed({1'b0, rate}); mb = 17'(p_r); end
      default: begin ma = 17'sd0;               mb = 17'sd0; end
    endcase
  end

  // weight update: w + floor((rate*p + 2^15) / 2^16)
  assign delta = (prod_x + 40'sd32768) >>> 16;
  assign w_upd = sat16(40'(w_q_r) + delta);
  assign grad_val = sat16(rnd12(prod_x));

  // tanh interpolation: lookup and slope, then the final magnitude
  assign t_abs = e_r[15] ? 17'(-(17'(e_r))) : {1'b0, e_r};
  assign t1 = tanh_lut({1'b0, t_abs[14:10]} + 6'd1);
  assign tdiff = t1 - tanh_lut({1'b0, t_abs[14:10]});
  assign tround = tprod_r + 20'd512;
  assign t_mag = big_r ? 13'd4096 : t0_r + 13'(tround[19:10]);

  assign w_we = (cmd.op == DP_WR_W) || (cmd.op == DP_WUPD);
  assign w_wdata = (cmd.op == DP_WR_W) ? cmd.data : w_upd;
  assign n_we = (cmd.op == DP_WR_IN) || (cmd.op == DP_TANH_B);
  assign n_wdata = (cmd.op == DP_WR_IN) ? cmd.data
                 : (neg_r ? -$signed({3'b000, t_mag}) : $signed({3'b000, t_mag}));

  always_ff @(posedge clk) begin
    if (w_we) wmem[cmd.w_addr] <= w_wdata;
    if (n_we) nmem[n_idx] <= n_wdata;
    if (cmd.op == DP_GRAD) gmem[cmd.g_addr] <= grad_val;
    if (cmd.op == DP_RD) begin
      w_q_r    <= wmem[cmd.w_addr];
      n_q_r    <= nmem[n_idx];
      g_q_r    <= gmem[cmd.g_addr];
      t_q_r    <= tgt_r[cmd.t_idx];
      n_bias_r <= cmd.n_addr[4];
      n_vld_r  <= nvalid_r[n_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvalid_r <= '0;
      for (int i = 0; i < MAXN; i++) tgt_r[i] <= 16'sd0;
    end else begin
      if (n_we) nvalid_r[n_idx] <= 1'b1;
      if (cmd.op == DP_WR_TGT) tgt_r[cmd.t_idx] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MS_NONE) prod_r <= ma * mb;
    case (cmd.op)
      DP_ACC_CLR: acc_r <= 40'sd0;
      DP_ACC:     acc_r <= acc_r + prod_x;
      DP_RND:     e_r <= sat16(rnd12(acc_r));
      DP_ERR:     e_r <= sat16(40'(t_q_r) - 40'(nv));
      DP_DER:     d_r <= sat16(40'sd4096 - rnd12(prod_x));
      DP_PRND:    p_r <= grad_val;
      DP_GLATCH:  g_hold_r <= g_q_r;
      DP_TANH_A: begin
        neg_r   <= e_r[15];
        big_r   <= t_abs[16] | t_abs[15];
        t0_r    <= tanh_lut({1'b0, t_abs[14:10]});
        tprod_r <= 20'(tdiff[9:0] * t_abs[9:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_OUT_LD || cmd.op == DP_DONE_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT_LD) begin
      out_kind_r <= KIND_VALUE;
      out_idx_r  <= cmd.out_idx;
      out_val_r  <= nv;
      out_last_r <= cmd.out_last;
    end else if (cmd.op == DP_DONE_LD) begin
      out_kind_r <= KIND_DONE;
      out_idx_r  <= 4'd0;
      out_val_r  <= 16'sd0;
      out_last_r <= 1'b1;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_idx   = out_idx_r;
  assign out_val   = out_val_r;
  assign out_last  = out_last_r;

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_OUT_LD || cmd.op == DP_DONE_LD) |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten");

endmodule

// ----- rtl/mbt_ctrl.sv -----
`timescale 1ns / 1ps
module mbt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  mbt_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [1:0]         in_source_layer,
  input  logic [4:0]         in_source_index,
  input  logic [3:0]         in_dest_index,
  input  logic signed [15:0] in_value,
  input  logic               in_last,
  input  mbt_pkg::dp_sts_t   sts,
  output mbt_pkg::dp_cmd_t   cmd
);
  import mbt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_F_CLR, S_F_RD, S_F_MUL, S_F_ACC, S_F_RND, S_F_TA, S_F_TB,
    S_E_RD, S_E_LD,
    S_G_RD, S_G_ERR,
    S_H_CLR, S_H_RD, S_H_MUL, S_H_ACC, S_H_YRD, S_H_RND,
    S_D_DER, S_D_MUL, S_D_WR,
    S_U_GRD, S_U_GL, S_U_RD, S_U_MUL, S_U_PR, S_U_MULR, S_U_WR,
    S_T_DONE
  } state_t;

  function automatic logic [W_AW-1:0] waddr(input logic [1:0] l, input logic [4:0] s,
                                            input logic [3:0] d);
    logic [5:0] row;
    row = {l, 4'b0000} + {4'b0000, l} + {1'b0, s};
    return {row, d};
  endfunction

  function automatic logic [4:0] fix_size(input logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (v > 5'd16) r = 5'd16;
    else r = v;
    return r;
  endfunction

  state_t      state_r, state_nxt;
  logic [1:0]  l_r, l_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [4:0]  s_r, s_nxt;
  logic [3:0]  k_r, k_nxt;
  dp_cmd_t     cmd_r, cmd_nxt;

  logic [4:0]  sz [4];
  logic [2:0]  lay_n;
  logic [1:0]  lo, lp, ln;
  logic [4:0]  n_inc, k_inc, ns_cur, nd_cur, np_cur;
  logic [4:0]  s_fwd, s_upd;
  logic        in_fire;

  assign sz[0] = fix_size(cfg.size0);
  assign sz[1] = fix_size(cfg.size1);
  assign sz[2] = fix_size(cfg.size2);
  assign sz[3] = fix_size(cfg.size3);
  assign lay_n = (cfg.layer_count < 3'd2) ? 3'd2
               : ((cfg.layer_count > 3'd4) ? 3'd4 : cfg.layer_count);
  assign lo = 2'(lay_n - 3'd1);
  assign lp = l_r - 2'd1;
  assign ln = l_r + 2'd1;
  assign ns_cur = sz[l_r];
  assign nd_cur = sz[ln];
  assign np_cur = sz[lp];
  assign n_inc = {1'b0, n_r} + 5'd1;
  assign k_inc = {1'b0, k_r} + 5'd1;
  // sources run over the real neurons, then the bias slot
  assign s_fwd = (s_r == ns_cur - 5'd1) ? 5'd16 : s_r + 5'd1;
  assign s_upd = (s_r == np_cur - 5'd1) ? 5'd16 : s_r + 5'd1;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign cmd = cmd_r;

  always_comb begin
    state_nxt = state_r;
    l_nxt = l_r;
    n_nxt = n_r;
    s_nxt = s_r;
    k_nxt = k_r;
    cmd_nxt = '0;
    cmd_nxt.op = DP_NOP;
    cmd_nxt.mul = MS_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_operation)
            OP_WEIGHT: begin
              if (in_source_layer < 2'd3 && in_source_index <= 5'd16) begin
                cmd_nxt.op = DP_WR_W;
                cmd_nxt.w_addr = waddr(in_source_layer, in_source_index, in_dest_index);
                cmd_nxt.data = in_value;
              end
            end
            OP_INPUT: begin
              if (!in_source_index[4]) begin
                cmd_nxt.op = DP_WR_IN;
                cmd_nxt.n_addr = {2'd0, in_source_index};
                cmd_nxt.data = in_value;
              end
              if (in_last) begin
                l_nxt = 2'd0;
                n_nxt = 4'd0;
                state_nxt = S_F_CLR;
              end
            end
            OP_TARGET: begin
              if (!in_source_index[4]) begin
                cmd_nxt.op = DP_WR_TGT;
                cmd_nxt.t_idx = in_source_index[3:0];
                cmd_nxt.data = in_value;
              end
              if (in_last) begin
                l_nxt = lo;
                n_nxt = 4'd0;
                state_nxt = S_G_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // forward pass
      S_F_CLR: begin
        cmd_nxt.op = DP_ACC_CLR;
        s_nxt = 5'd0;
        state_nxt = S_F_RD;
      end
      S_F_RD: begin
        cmd_nxt.op = DP_RD;
        cmd_nxt.w_addr = waddr(l_r, s_r, n_r);
        cmd_nxt.n_addr = {l_r, s_r};
        state_nxt = S_F_MUL;
      end
      S_F_MUL: begin
        cmd_nxt.mul = MS_NW;
        state_nxt = S_F_ACC;
      end
      S_F_ACC: begin
        cmd_nxt.op = DP_ACC;
        if (s_r == 5'd16) begin
          state_nxt = S_F_RND;
        end else begin
          s_nxt = s_fwd;
          state_nxt = S_F_RD;
        end
      end
      S_F_RND: begin
        cmd_nxt.op = DP_RND;
        state_nxt = S_F_TA;
      end
      S_F_TA: begin
        cmd_nxt.op = DP_TANH_A;
        state_nxt = S_F_TB;
      end
      S_F_TB: begin
        cmd_nxt.op = DP_TANH_B;
        cmd_nxt.n_addr = {ln, 1'b0, n_r};
        if (n_inc < nd_cur) begin
          n_nxt = n_r + 4'd1;
          state_nxt = S_F_CLR;
        end else if (ln == lo) begin
          l_nxt = lo;
          n_nxt = 4'd0;
          state_nxt = S_E_RD;
        end else begin
          l_nxt = ln;
          n_nxt = 4'd0;
          state_nxt = S_F_CLR;
        end
      end
      // emit output layer
      S_E_RD: begin
        cmd_nxt.op = DP_RD;
        cmd_nxt.n_addr = {l_r, 1'b0, n_r};
        state_nxt = S_E_LD;
      end
      S_E_LD: begin
        if (!sts.out_busy) begin
          cmd_nxt.op = DP_OUT_LD;
          cmd_nxt.out_idx = n_r;
          cmd_nxt.out_last = (n_inc == ns_cur);
          if (n_inc == ns_cur) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt = n_r + 4'd1;
            state_nxt = S_E_RD;
          end
        end
      end
      // output layer gradients
      S_G_RD: begin
        cmd_nxt.op = DP_RD;
        cmd_nxt.n_addr = {l_r, 1'b0, n_r};
        cmd_nxt.t_idx = n_r;
        state_nxt = S_G_ERR;
      end
      S_G_ERR: begin
        cmd_nxt.op = DP_ERR;
        cmd_nxt.mul = MS_YY;
        state_nxt = S_D_DER;
      end
      // hidden gradients
      S_H_CLR: begin
        cmd_nxt.op = DP_ACC_CLR;
        k_nxt = 4'd0;
        state_nxt = S_H_RD;
      end
      S_H_RD: begin
        cmd_nxt.op = DP_RD;
        cmd_nxt.w_addr = waddr(l_r, {1'b0, n_r}, k_r);
        cmd_nxt.g_addr = {ln, k_r};
        state_nxt = S_H_MUL;
      end
      S_H_MUL: begin
        cmd_nxt.mul = MS_WG;
        state_nxt = S_H_ACC;
      end
      S_H_ACC: begin
        cmd_nxt.op = DP_ACC;
        if (k_inc < nd_cur) begin
          k_nxt = k_r + 4'd1;
          state_nxt = S_H_RD;
        end else begin
          state_nxt = S_H_YRD;
        end
      end
      S_H_YRD: begin
        cmd_nxt.op = DP_RD;
        cmd_nxt.n_addr = {l_r, 1'b0, n_r};
        state_nxt = S_H_RND;
      end
      S_H_RND: begin
        cmd_nxt.op = DP_RND;
        cmd_nxt.mul = MS_YY;
        state_nxt = S_D_DER;
      end
      // shared tail: gradient = err * (1 - y^2)
      S_D_DER: begin
        cmd_nxt.op = DP_DER;
        state_nxt = S_D_MUL;
      end
      S_D_MUL: begin
        cmd_nxt.mul = MS_ED;
        state_nxt = S_D_WR;
      end
      S_D_WR: begin
        cmd_nxt.op = DP_GRAD;
        cmd_nxt.g_addr = {l_r, n_r};
        if (n_inc < ns_cur) begin
          n_nxt = n_r + 4'd1;
          state_nxt = (l_r == lo) ? S_G_RD : S_H_CLR;
        end else if (l_r == 2'd1) begin
          l_nxt = lo;
          n_nxt = 4'd0;
          state_nxt = S_U_GRD;
        end else begin
          l_nxt = lp;
          n_nxt = 4'd0;
          state_nxt = S_H_CLR;
        end
      end
      // weight update
      S_U_GRD: begin
        cmd_nxt.op = DP_RD;
        cmd_nxt.g_addr = {l_r, n_r};
        state_nxt = S_U_GL;
      end
      S_U_GL: begin
        cmd_nxt.op = DP_GLATCH;
        s_nxt = 5'd0;
        state_nxt = S_U_RD;
      end
      S_U_RD: begin
        cmd_nxt.op = DP_RD;
        cmd_nxt.w_addr = waddr(lp, s_r, n_r);
        cmd_nxt.n_addr = {lp, s_r};
        state_nxt = S_U_MUL;
      end
      S_U_MUL: begin
        cmd_nxt.mul = MS_NG;
        state_nxt = S_U_PR;
      end
      S_U_PR: begin
        cmd_nxt.op = DP_PRND;
        state_nxt = S_U_MULR;
      end
      S_U_MULR: begin
        cmd_nxt.mul = MS_LP;
        state_nxt = S_U_WR;
      end
      S_U_WR: begin
        cmd_nxt.op = DP_WUPD;
        cmd_nxt.w_addr = waddr(lp, s_r, n_r);
        if (s_r != 5'd16) begin
          s_nxt = s_upd;
          state_nxt = S_U_RD;
        end else if (n_inc < ns_cur) begin
          n_nxt = n_r + 4'd1;
          state_nxt = S_U_GRD;
        end else if (l_r == 2'd1) begin
          state_nxt = S_T_DONE;
        end else begin
          l_nxt = lp;
          n_nxt = 4'd0;
          state_nxt = S_U_GRD;
        end
      end
      S_T_DONE: begin
        if (!sts.out_busy) begin
          cmd_nxt.op = DP_DONE_LD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      l_r <= 2'd0;
      n_r <= 4'd0;
      s_r <= 5'd0;
      k_r <= 4'd0;
      cmd_r <= '0;
    end else begin
      state_r <= state_nxt;
      l_r <= l_nxt;
      n_r <= n_nxt;
      s_r <= s_nxt;
      k_r <= k_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  a_src_range: assert property (@(posedge clk) disable iff (!rst_n) s_r <= 5'd16)
    else $error("source counter out of range");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && $past(state_r) == S_IDLE) |-> $past(in_fire))
    else $error("left idle without an item");

  a_grad_layer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_WR || state_r == S_U_WR) |-> l_r != 2'd0)
    else $error("gradient work on input layer");

endmodule
